>>> design/tlfk_pkg.sv
`timescale 1ns / 1ps

package tlfk_pkg;

  // Rotation steps; the arctangent table holds at most ATAN_LEN entries.
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned ATAN_LEN     = 24;
  localparam int unsigned NSTAGES      = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

  localparam int unsigned TURN_UNITS    = 23040;
  localparam int unsigned QUARTER_UNITS = 5760;
  localparam int unsigned ANGLE_SHIFT   = 14;

  localparam int unsigned ANGLE_W = 15;   // 0 .. TURN_UNITS-1
  localparam int unsigned REST_W  = 13;   // 0 .. QUARTER_UNITS-1
  localparam int unsigned CVAL_W  = 32;   // Q1.30 and 2^-20 degree

  localparam logic signed [CVAL_W-1:0] GAIN_Q30 = 32'sd652032874;

  // Configuration register indexes
  typedef enum logic {
    REG_FIRST_LINK  = 1'b0,
    REG_SECOND_LINK = 1'b1
  } link_reg_t;

  typedef logic [ANGLE_W-1:0]        angle_t;
  typedef logic [REST_W-1:0]         rest_t;
  typedef logic [1:0]                quad_t;
  typedef logic signed [CVAL_W-1:0]  cval_t;
  typedef logic [15:0]               link_t;

  typedef struct packed {
    cval_t x;
    cval_t y;
    cval_t z;
  } lane_t;

  // One item in flight through the rotator: shoulder lane and summed lane.
  typedef struct packed {
    lane_t a;
    lane_t b;
    quad_t qa;
    quad_t qb;
  } cord_item_t;

  // atan(2^-i) in units of 2^-20 degree, rounded to nearest.
  function automatic cval_t atan_val(input logic [4:0] i);
    cval_t v;
    case (i)
      5'd0:    v = 32'sd47185920;
      5'd1:    v = 32'sd27855475;
      5'd2:    v = 32'sd14718068;
      5'd3:    v = 32'sd7471121;
      5'd4:    v = 32'sd3750058;
      5'd5:    v = 32'sd1876857;
      5'd6:    v = 32'sd938658;
      5'd7:    v = 32'sd469357;
      5'd8:    v = 32'sd234682;
      5'd9:    v = 32'sd117342;
      5'd10:   v = 32'sd58671;
      5'd11:   v = 32'sd29335;
      5'd12:   v = 32'sd14668;
      5'd13:   v = 32'sd7334;
      5'd14:   v = 32'sd3667;
      5'd15:   v = 32'sd1833;
      5'd16:   v = 32'sd917;
      5'd17:   v = 32'sd458;
      5'd18:   v = 32'sd229;
      5'd19:   v = 32'sd115;
      5'd20:   v = 32'sd57;
      5'd21:   v = 32'sd29;
      5'd22:   v = 32'sd14;
      5'd23:   v = 32'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> design/tlfk_if.sv
`timescale 1ns / 1ps

interface tlfk_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] shoulder_angle;
  logic signed [15:0] elbow_angle;

  modport source (output valid, output shoulder_angle, output elbow_angle, input ready);
  modport sink   (input valid, input shoulder_angle, input elbow_angle, output ready);
endinterface

interface tlfk_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] tip_x;
  logic signed [17:0] tip_y;

  modport source (output valid, output tip_x, output tip_y, input ready);
  modport sink   (input valid, input tip_x, input tip_y, output ready);
endinterface

>>> design/tlfk_cordic.sv
`timescale 1ns / 1ps

module tlfk_cordic
  import tlfk_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  cord_item_t up_item,
  output logic       dn_valid,
  input  logic       dn_ready,
  output cord_item_t dn_item
);

  cord_item_t stage_r [NSTAGES];
  logic       valid_r [NSTAGES];
  logic       en      [NSTAGES+1];

  // Load a stage when it is empty or its content moves on.
  always_comb begin
    en[NSTAGES] = dn_ready;
    for (int k = NSTAGES - 1; k >= 0; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
  end

  assign up_ready = en[0];
  assign dn_valid = valid_r[NSTAGES-1];
  assign dn_item  = stage_r[NSTAGES-1];

  for (genvar k = 0; k < NSTAGES; k++) begin : g_step
    cord_item_t src;
    logic       src_valid;
    cord_item_t step_nxt;

    if (k == 0) begin : g_first
      assign src       = up_item;
      assign src_valid = up_valid;
    end else begin : g_rest
      assign src       = stage_r[k-1];
      assign src_valid = valid_r[k-1];
    end

    // Rotate both lanes by +/- atan(2^-k); arithmetic shift floors.
    always_comb begin
      step_nxt    = src;
      if (!src.a.z[CVAL_W-1]) begin
        step_nxt.a.x = src.a.x - (src.a.y >>> k);
        step_nxt.a.y = src.a.y + (src.a.x >>> k);
        step_nxt.a.z = src.a.z - atan_val(5'(k));
      end else begin
        step_nxt.a.x = src.a.x + (src.a.y >>> k);
        step_nxt.a.y = src.a.y - (src.a.x >>> k);
        step_nxt.a.z = src.a.z + atan_val(5'(k));
      end
      if (!src.b.z[CVAL_W-1]) begin
        step_nxt.b.x = src.b.x - (src.b.y >>> k);
        step_nxt.b.y = src.b.y + (src.b.x >>> k);
        step_nxt.b.z = src.b.z - atan_val(5'(k));
      end else begin
        step_nxt.b.x = src.b.x + (src.b.y >>> k);
        step_nxt.b.y = src.b.y - (src.b.x >>> k);
        step_nxt.b.z = src.b.z + atan_val(5'(k));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en[k]) begin
        valid_r[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k] && src_valid) begin
        stage_r[k] <= step_nxt;
      end
    end
  end

endmodule

>>> design/two_link_arm_forward_kinematics.sv
`timescale 1ns / 1ps

// Forward kinematics of a two-link planar arm. Each transfer on in_chan carries
// a shoulder and an elbow angle in 1/64 degree; each transfer on out_chan gives
// the tool-tip position tip_x = L1*cos(a1) + L2*cos(a1+a2) and tip_y likewise
// with sine, in 1/256 length units, rounded to nearest (halves up) and
// saturated to 18 bits. L1 and L2 are Q8.8 registers written through cfg_*
// (index 0 and 1, reset 1.0); write them only while no item is in flight.
// The block is a fully pipelined datapath: one angle pair is accepted every
// cycle while out_chan takes results. An item passes the turn reduction and
// quadrant split stages, NSTAGES rotation stages (16 by default, one per
// CORDIC step), then the quadrant, multiply and output stages. Each stage
// holds its own valid bit, so a stall on out_chan fills empty stages before
// in_chan stops taking transfers, and nothing is lost or repeated.

module two_link_arm_forward_kinematics
  import tlfk_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  tlfk_in_if.sink           in_chan,
  tlfk_out_if.source        out_chan,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data
);

  localparam logic signed [18:0] TURN1 = 19'(TURN_UNITS);
  localparam logic signed [18:0] TURN2 = 19'(2 * TURN_UNITS);
  localparam logic signed [18:0] TURN3 = 19'(3 * TURN_UNITS);
  localparam angle_t Q1 = ANGLE_W'(QUARTER_UNITS);
  localparam angle_t Q2 = ANGLE_W'(2 * QUARTER_UNITS);
  localparam angle_t Q3 = ANGLE_W'(3 * QUARTER_UNITS);

  // Bring an angle in [-65536, 65534] into one turn.
  function automatic angle_t reduce_turn(input logic signed [16:0] a);
    logic signed [18:0] ax;
    logic signed [18:0] r;
    ax = {{2{a[16]}}, a};
    if (ax >= TURN2) begin
      r = ax - TURN2;
    end else if (ax >= TURN1) begin
      r = ax - TURN1;
    end else if (ax >= 0) begin
      r = ax;
    end else if (ax >= -TURN1) begin
      r = ax + TURN1;
    end else if (ax >= -TURN2) begin
      r = ax + TURN2;
    end else begin
      r = ax + TURN3;
    end
    return ANGLE_W'(r);
  endfunction

  // Split into a quadrant and a residue below 90 degrees.
  function automatic quad_t quad_of(input angle_t a);
    quad_t q;
    if (a >= Q3) begin
      q = 2'd3;
    end else if (a >= Q2) begin
      q = 2'd2;
    end else if (a >= Q1) begin
      q = 2'd1;
    end else begin
      q = 2'd0;
    end
    return q;
  endfunction

  function automatic rest_t rest_of(input angle_t a);
    angle_t r;
    if (a >= Q3) begin
      r = a - Q3;
    end else if (a >= Q2) begin
      r = a - Q2;
    end else if (a >= Q1) begin
      r = a - Q1;
    end else begin
      r = a;
    end
    return REST_W'(r);
  endfunction

  // Undo the quadrant split exactly by swap and negate.
  function automatic lane_t apply_quad(input lane_t l, input quad_t q);
    lane_t o;
    o = l;
    case (q)
      2'd0: begin o.x = l.x;  o.y = l.y;  end
      2'd1: begin o.x = -l.y; o.y = l.x;  end
      2'd2: begin o.x = -l.x; o.y = -l.y; end
      default: begin o.x = l.y; o.y = -l.x; end
    endcase
    return o;
  endfunction

  // Round the Q.38 sum to 1/256 units and clamp to 18 bits.
  function automatic logic signed [17:0] finish(input logic signed [49:0] acc);
    logic signed [49:0] t;
    logic signed [19:0] v;
    t = acc + (50'sd1 <<< 29);
    v = 20'(t >>> 30);
    if (v > 20'sd131071) begin
      return 18'sd131071;
    end else if (v < -20'sd131072) begin
      return -18'sd131072;
    end
    return 18'(v);
  endfunction

  // Link-length registers
  link_t l1_r, l2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_r <= 16'd256;
      l2_r <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST_LINK:  l1_r <= cfg_data;
        REG_SECOND_LINK: l2_r <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Stage handshake: load a stage when empty or when it drains.
  logic v0_r, v1_r, vq_r, vm_r, vf_r;
  logic en0, en1, enq, enm, enf;
  logic cord_ready, cord_valid;
  cord_item_t cord_in_r, cord_out;

  assign enf = !vf_r || out_chan.ready;
  assign enm = !vm_r || enf;
  assign enq = !vq_r || enm;
  assign en1 = !v1_r || cord_ready;
  assign en0 = !v0_r || en1;

  assign in_chan.ready = en0;

  // Stage 0: reduce the shoulder angle and the exact angle sum into one turn.
  angle_t ang1_r, ang2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en0) begin
      v0_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && in_chan.valid) begin
      ang1_r <= reduce_turn({in_chan.shoulder_angle[15], in_chan.shoulder_angle});
      ang2_r <= reduce_turn(17'(in_chan.shoulder_angle) + 17'(in_chan.elbow_angle));
    end
  end

  // Stage 1: quadrant split, seed the rotator with the gain-corrected unit vector.
  cord_item_t cord_in_nxt;

  always_comb begin
    cord_in_nxt.a.x = GAIN_Q30;
    cord_in_nxt.a.y = '0;
    cord_in_nxt.a.z = CVAL_W'(rest_of(ang1_r)) <<< ANGLE_SHIFT;
    cord_in_nxt.b.x = GAIN_Q30;
    cord_in_nxt.b.y = '0;
    cord_in_nxt.b.z = CVAL_W'(rest_of(ang2_r)) <<< ANGLE_SHIFT;
    cord_in_nxt.qa  = quad_of(ang1_r);
    cord_in_nxt.qb  = quad_of(ang2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && v0_r) begin
      cord_in_r <= cord_in_nxt;
    end
  end

  tlfk_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (v1_r),
    .up_ready (cord_ready),
    .up_item  (cord_in_r),
    .dn_valid (cord_valid),
    .dn_ready (enq),
    .dn_item  (cord_out)
  );

  // Quadrant stage: cos and sin of both angles.
  lane_t cs1_r, cs2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r <= 1'b0;
    end else if (enq) begin
      vq_r <= cord_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (enq && cord_valid) begin
      cs1_r <= apply_quad(cord_out.a, cord_out.qa);
      cs2_r <= apply_quad(cord_out.b, cord_out.qb);
    end
  end

  // Multiply stage: four 17x32 products, operands sign-extended to the full
  // product width so that no upper bits are lost.
  logic signed [48:0] px1_r, px2_r, py1_r, py2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (enm) begin
      vm_r <= vq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (enm && vq_r) begin
      px1_r <= 49'($signed({1'b0, l1_r})) * 49'(cs1_r.x);
      px2_r <= 49'($signed({1'b0, l2_r})) * 49'(cs2_r.x);
      py1_r <= 49'($signed({1'b0, l1_r})) * 49'(cs1_r.y);
      py2_r <= 49'($signed({1'b0, l2_r})) * 49'(cs2_r.y);
    end
  end

  // Output stage: add, round, clamp; this register holds until taken.
  logic signed [17:0] tip_x_r, tip_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (enf) begin
      vf_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (enf && vm_r) begin
      tip_x_r <= finish(50'(px1_r) + 50'(px2_r));
      tip_y_r <= finish(50'(py1_r) + 50'(py2_r));
    end
  end

  assign out_chan.valid = vf_r;
  assign out_chan.tip_x = tip_x_r;
  assign out_chan.tip_y = tip_y_r;

endmodule
